// ===== rtl/core/pet_pkg.sv =====
// ----------------------------------------------------------------------------
// Per-task tracker package
// Types, sizes and codes shared by the tracker controller and datapath.
// ----------------------------------------------------------------------------
package pet_pkg;

   localparam int MAX_TASKS      = 16;
   localparam int SLOTS_PER_TASK = 32;
   localparam int TASK_W         = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int SLOT_W         = (SLOTS_PER_TASK > 1) ? $clog2(SLOTS_PER_TASK) : 1;
   localparam int SLOT_DEPTH     = 2 ** (TASK_W + SLOT_W);

   typedef enum logic [2:0] {
      CMD_ADD    = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_EVENT  = 3'd2,
      CMD_ALLOC  = 3'd3,
      CMD_FREE   = 3'd4,
      CMD_READ   = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      EV_SCHED  = 3'd0,
      EV_UP     = 3'd1,
      EV_DOWN   = 3'd2,
      EV_LOCK   = 3'd3,
      EV_UNLOCK = 3'd4
   } ev_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNTRACKED = 2'd1,
      ST_TASK_FULL = 2'd2,
      ST_SLOT_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_READ,
      S_SCAN,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [21:0] process_id;
      logic [2:0]  event_kind;
      logic [31:0] alloc_size;
      logic [63:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] alloc_count;
      logic [31:0] free_count;
      logic [31:0] alloc_bytes;
      logic [31:0] freed_bytes;
      logic [31:0] sched_count;
      logic [31:0] up_count;
      logic [31:0] down_count;
      logic [31:0] lock_count;
      logic [31:0] unlock_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] alloc_count;
      logic [31:0] free_count;
      logic [31:0] alloc_bytes;
      logic [31:0] freed_bytes;
      logic [31:0] sched_count;
      logic [31:0] up_count;
      logic [31:0] down_count;
      logic [31:0] lock_count;
      logic [31:0] unlock_count;
   } cnt_type;

   typedef struct packed {
      logic [63:0] address;
      logic [31:0] size;
   } slot_type;

   typedef struct packed {
      logic load;
      logic match;
      logic cnt_rd;
      logic scan_init;
      logic scan;
      logic exec;
   } ctl_type;

   typedef struct packed {
      logic scan_need;
      logic scan_hit;
      logic scan_last;
   } sts_type;

endpackage

// ===== rtl/core/pet_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pet_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tracker controller
// Sequences lookup, counter read, slot scan and update for one command.
// ----------------------------------------------------------------------------
module pet_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pet_pkg::sts_type sts,
   output pet_pkg::ctl_type ctl
);
   import pet_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            ctl.match = 1'b1;
            state_in  = S_READ;
         end
         S_READ: begin
            ctl.cnt_rd    = 1'b1;
            ctl.scan_init = 1'b1;
            state_in      = sts.scan_need ? S_SCAN : S_EXEC;
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.scan_hit || sts.scan_last) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted command did not make the block busy.");
   a_exec_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |=> !busy)
      else $error("Block stayed busy after update.");
   a_scan_need: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> $past(state_ff) == S_SCAN || $past(sts.scan_need))
      else $error("Scan entered without a free to resolve.");

endmodule

// ===== rtl/core/pet_dp.sv =====
// ----------------------------------------------------------------------------
// Tracker datapath
// Process table, slot valid rows, counter and slot memories, result register.
// ----------------------------------------------------------------------------
module pet_dp (
   input  logic             clock,
   input  logic             reset,
   input  pet_pkg::req_type req_item,
   input  pet_pkg::ctl_type ctl,
   output pet_pkg::sts_type sts,
   output logic             rsp_strobe,
   output pet_pkg::rsp_type rsp_item
);
   import pet_pkg::*;

   req_type                                 req_ff;
   logic [MAX_TASKS-1:0]                    entry_valid_ff;
   logic [MAX_TASKS-1:0][21:0]              entry_pid_ff;
   logic [MAX_TASKS-1:0][SLOTS_PER_TASK-1:0] slot_row_ff;
   logic [TASK_W-1:0]                       t_ff;
   logic                                    found_ff, add_ok_ff;
   logic [SLOT_W:0]                         k_ff;
   logic [SLOT_W-1:0]                       pk_ff, hit_k_ff;
   logic                                    pend_ff, hit_ff;
   logic [31:0]                             freed_ff;
   logic                                    rsp_strobe_ff;
   rsp_type                                 rsp_ff;

   logic                      hit_any, free_any, slot_free_any, k_done;
   logic [TASK_W-1:0]         hit_idx, free_idx;
   logic [SLOT_W-1:0]         free_slot;
   logic [SLOTS_PER_TASK-1:0] row_cur;
   cnt_type                   cnt_rdata, cnt_new;
   slot_type                  slot_rdata, slot_wdata;
   logic                      cnt_wr, slot_wr, zero_out;
   status_type                status;

   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (entry_valid_ff[i] && entry_pid_ff[i] == req_ff.process_id) begin
            hit_any = 1'b1;
            hit_idx = TASK_W'(i);
         end
         if (!entry_valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = TASK_W'(i);
         end
      end
   end

   assign row_cur = slot_row_ff[t_ff];

   always_comb begin
      slot_free_any = 1'b0;
      free_slot     = '0;
      for (int j = SLOTS_PER_TASK - 1; j >= 0; j--) begin
         if (!row_cur[j]) begin
            slot_free_any = 1'b1;
            free_slot     = SLOT_W'(j);
         end
      end
   end

   assign k_done        = (k_ff == (SLOT_W + 1)'(SLOTS_PER_TASK));
   assign sts.scan_need = (req_ff.command == CMD_FREE) && found_ff && (req_ff.address != '0);
   assign sts.scan_hit  = pend_ff && row_cur[pk_ff] && (slot_rdata.address == req_ff.address);
   assign sts.scan_last = pend_ff && (pk_ff == SLOT_W'(SLOTS_PER_TASK - 1));

   pet_ram #(.WIDTH($bits(cnt_type)), .DEPTH(2 ** TASK_W)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr),
      .wr_addr (t_ff),
      .wr_data (cnt_new),
      .rd_en   (ctl.cnt_rd),
      .rd_addr (t_ff),
      .rd_data (cnt_rdata)
   );

   assign slot_wdata.address = req_ff.address;
   assign slot_wdata.size    = req_ff.alloc_size;

   pet_ram #(.WIDTH($bits(slot_type)), .DEPTH(SLOT_DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr),
      .wr_addr ({t_ff, free_slot}),
      .wr_data (slot_wdata),
      .rd_en   (ctl.scan && !k_done),
      .rd_addr ({t_ff, k_ff[SLOT_W-1:0]}),
      .rd_data (slot_rdata)
   );

   always_comb begin
      cnt_new  = cnt_rdata;
      status   = ST_OK;
      cnt_wr   = 1'b0;
      slot_wr  = 1'b0;
      zero_out = 1'b0;
      if (req_ff.command == CMD_ADD) begin
         cnt_new = '0;
         if (add_ok_ff) begin
            cnt_wr = ctl.exec;
         end else begin
            status   = ST_TASK_FULL;
            zero_out = 1'b1;
         end
      end else if (!found_ff) begin
         status   = ST_UNTRACKED;
         zero_out = 1'b1;
      end else begin
         case (req_ff.command)
            CMD_REMOVE: begin
               zero_out = 1'b1;
            end
            CMD_EVENT: begin
               cnt_wr = ctl.exec;
               case (req_ff.event_kind)
                  EV_SCHED:  cnt_new.sched_count  = cnt_rdata.sched_count + 32'd1;
                  EV_UP:     cnt_new.up_count     = cnt_rdata.up_count + 32'd1;
                  EV_DOWN:   cnt_new.down_count   = cnt_rdata.down_count + 32'd1;
                  EV_LOCK:   cnt_new.lock_count   = cnt_rdata.lock_count + 32'd1;
                  EV_UNLOCK: cnt_new.unlock_count = cnt_rdata.unlock_count + 32'd1;
                  default:   cnt_new = cnt_rdata;
               endcase
            end
            CMD_ALLOC: begin
               cnt_wr = ctl.exec;
               cnt_new.alloc_count = cnt_rdata.alloc_count + 32'd1;
               if (req_ff.alloc_size != '0) begin
                  cnt_new.alloc_bytes = cnt_rdata.alloc_bytes + req_ff.alloc_size;
                  if (req_ff.address != '0) begin
                     if (slot_free_any) begin
                        slot_wr = ctl.exec;
                     end else begin
                        status = ST_SLOT_FULL;
                     end
                  end
               end
            end
            CMD_FREE: begin
               cnt_wr = ctl.exec;
               cnt_new.free_count  = cnt_rdata.free_count + 32'd1;
               cnt_new.freed_bytes = cnt_rdata.freed_bytes + freed_ff;
            end
            default: cnt_new = cnt_rdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_item;
      end
      if (ctl.match) begin
         t_ff      <= hit_any ? hit_idx : free_idx;
         found_ff  <= hit_any;
         add_ok_ff <= hit_any || free_any;
      end
      if (ctl.scan_init) begin
         k_ff     <= '0;
         pend_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         freed_ff <= '0;
      end else if (ctl.scan) begin
         if (sts.scan_hit) begin
            hit_ff   <= 1'b1;
            hit_k_ff <= pk_ff;
            freed_ff <= slot_rdata.size;
         end else if (!k_done) begin
            k_ff    <= k_ff + 1'b1;
            pk_ff   <= k_ff[SLOT_W-1:0];
            pend_ff <= 1'b1;
         end
      end
      if (ctl.exec) begin
         rsp_ff.status       <= status;
         rsp_ff.alloc_count  <= zero_out ? '0 : cnt_new.alloc_count;
         rsp_ff.free_count   <= zero_out ? '0 : cnt_new.free_count;
         rsp_ff.alloc_bytes  <= zero_out ? '0 : cnt_new.alloc_bytes;
         rsp_ff.freed_bytes  <= zero_out ? '0 : cnt_new.freed_bytes;
         rsp_ff.sched_count  <= zero_out ? '0 : cnt_new.sched_count;
         rsp_ff.up_count     <= zero_out ? '0 : cnt_new.up_count;
         rsp_ff.down_count   <= zero_out ? '0 : cnt_new.down_count;
         rsp_ff.lock_count   <= zero_out ? '0 : cnt_new.lock_count;
         rsp_ff.unlock_count <= zero_out ? '0 : cnt_new.unlock_count;
         if (req_ff.command == CMD_ADD && add_ok_ff) begin
            entry_pid_ff[t_ff] <= req_ff.process_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         slot_row_ff    <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.exec;
         if (ctl.exec) begin
            if (req_ff.command == CMD_ADD && add_ok_ff) begin
               entry_valid_ff[t_ff] <= 1'b1;
               slot_row_ff[t_ff]    <= '0;
            end else if (req_ff.command == CMD_REMOVE && found_ff) begin
               entry_valid_ff[t_ff] <= 1'b0;
               slot_row_ff[t_ff]    <= '0;
            end else if (slot_wr) begin
               slot_row_ff[t_ff][free_slot] <= 1'b1;
            end else if (req_ff.command == CMD_FREE && hit_ff) begin
               slot_row_ff[t_ff][hit_k_ff] <= 1'b0;
            end
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe lasted more than one cycle.");
   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      !entry_valid_ff[t_ff] |-> slot_row_ff[t_ff] == '0)
      else $error("Free process entry holds allocation slots.");
   a_hit_free: assert property (@(posedge clock) disable iff (reset)
      hit_ff && ctl.exec |-> req_ff.command == CMD_FREE && found_ff)
      else $error("Slot match recorded outside a tracked free.");

endmodule

// ===== rtl/core/per_task_event_and_alloc_tracker_core.sv =====
// A command steps through lookup, counter read and update; the result strobe
// is registered. A tracked free of a nonzero address scans the slot memory
// before the update, one slot per cycle. Busy is high and start is ignored until idle.
// Reset clears the process table and slot valid rows at once; no sweep.
// ----------------------------------------------------------------------------
// Per-task event and allocation tracker
// Counts events and allocations for a table of tracked processes.
// ----------------------------------------------------------------------------
module per_task_event_and_alloc_tracker_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pet_pkg::req_type req_item,
   output logic             rsp_strobe,
   output pet_pkg::rsp_type rsp_item
);
   import pet_pkg::*;

   ctl_type ctl;
   sts_type sts;

   pet_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   pet_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
